### design/kvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared codes, widths and the control bundle of the key/value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

    // fixed field widths
    localparam int REQ_BITS    = 2;
    localparam int STATUS_BITS = 3;
    localparam int COUNT_BITS  = 5;
    localparam int CAP_BITS    = 5;

    // capacity after reset
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // request types
    localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_REPLACED = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_MISSING  = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_REMOVED  = 3'd5;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic match_en;   // compare phase: latch key match
        logic replace;    // overwrite value of matching cell
        logic append;     // write key and value into first free cell
        logic move;       // copy last entry into matching cell
    } kvt_ctrl_t;

endpackage
`default_nettype wire

### design/kvt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_cell
// One table slot: holds a key and value, latches a match flag and adds its
// contribution to the result chain passed on to its lower neighbor.
// ----------------------------------------------------------------------------
module kvt_cell #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32,
    parameter int INDEX       = 0
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  kvt_pkg::kvt_ctrl_t                  ctrl,
    input  wire [$clog2(MAX_ENTRIES+1)-1:0]     count,
    input  wire [KEY_BITS-1:0]                  req_key,
    input  wire [VALUE_BITS-1:0]                req_value,
    input  wire [KEY_BITS-1:0]                  last_key,
    input  wire [VALUE_BITS-1:0]                last_value,
    // chain from upper neighbor
    input  wire                                 hit_in,
    input  wire [VALUE_BITS-1:0]                rv_in,
    input  wire [KEY_BITS-1:0]                  lk_in,
    input  wire [VALUE_BITS-1:0]                lv_in,
    // chain to lower neighbor
    output logic                                hit_out,
    output logic [VALUE_BITS-1:0]               rv_out,
    output logic [KEY_BITS-1:0]                 lk_out,
    output logic [VALUE_BITS-1:0]               lv_out
);
    import kvt_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  match_reg;
    logic                  occupied;
    logic                  is_last;
    logic                  is_free_head;

    // slot position relative to the fill level
    assign occupied     = CW'(INDEX) < count;
    assign is_last      = CW'(INDEX + 1) == count;
    assign is_free_head = CW'(INDEX) == count;

    // match flag, latched in the compare phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (ctrl.match_en) begin
            match_reg <= occupied && (key_reg == req_key);
        end
    end

    // slot contents
    always_ff @(posedge aclk) begin
        if (ctrl.replace && match_reg) begin
            value_reg <= req_value;
        end
        if (ctrl.append && is_free_head) begin
            key_reg   <= req_key;
            value_reg <= req_value;
        end
        if (ctrl.move && match_reg) begin
            key_reg   <= last_key;
            value_reg <= last_value;
        end
    end

    // chain contributions
    always_comb begin
        hit_out = hit_in | match_reg;
        rv_out  = rv_in | (match_reg ? value_reg : '0);
        lk_out  = lk_in | (is_last ? key_reg : '0);
        lv_out  = lv_in | (is_last ? value_reg : '0);
    end

endmodule
`default_nettype wire

### design/key_value_table_unit.sv
`default_nettype none
// Result beat is registered: a taken request runs a compare cycle in which
// every cell checks its key, then an update cycle that writes the cells and
// the output register; the next request can be taken in that update cycle.
// A stalled result holds the update cycle until the output register frees.
// Reset empties the table and sets capacity to 16; slot contents are not cleared.
// ----------------------------------------------------------------------------
// key_value_table_unit
// Unsorted associative table of unique keys built as a row of slot cells,
// serving insert, lookup and remove requests with a status and entry count.
// ----------------------------------------------------------------------------
module key_value_table_unit #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  wire                                              aclk,
    input  wire                                              aresetn,
    // request channel
    input  wire                                              s_tvalid,
    output logic                                             s_tready,
    // tdata: key, value
    input  wire [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]          s_tdata,
    // tuser: req_type
    input  wire [kvt_pkg::REQ_BITS-1:0]                      s_tuser,
    // result channel
    output logic                                             m_tvalid,
    input  wire                                              m_tready,
    // tdata: read_value, count
    output logic [((VALUE_BITS+kvt_pkg::COUNT_BITS+7)/8)*8-1:0] m_tdata,
    // tuser: status
    output logic [kvt_pkg::STATUS_BITS-1:0]                  m_tuser,
    // capacity register write
    input  wire                                              cfg_valid,
    output logic                                             cfg_ready,
    input  wire [kvt_pkg::CAP_BITS-1:0]                      cfg_data
);
    import kvt_pkg::*;

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int LW   = (CW > CAP_BITS) ? CW : CAP_BITS;
    localparam int M_W  = ((VALUE_BITS + COUNT_BITS + 7) / 8) * 8;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MATCH  = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CAP_BITS-1:0]    cap_reg;
    logic [CW-1:0]          count_reg;
    logic [REQ_BITS-1:0]    req_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [VALUE_BITS-1:0]  value_reg;
    logic [KEY_BITS-1:0]    last_key_reg;
    logic [VALUE_BITS-1:0]  last_value_reg;
    logic                   m_valid_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [VALUE_BITS-1:0]  rv_reg;
    logic [COUNT_BITS-1:0]  cnt_out_reg;

    logic                   out_free;
    logic                   accept;
    logic                   update_fire;
    logic                   hit;
    logic                   room;
    logic [LW-1:0]          limit;
    logic [LW-1:0]          cap_ext;
    kvt_ctrl_t              ctrl;
    logic [STATUS_BITS-1:0] status_next;
    logic [VALUE_BITS-1:0]  rv_next;
    logic [CW-1:0]          count_next;

    // cell chain taps, index MAX_ENTRIES is the empty top end
    logic                   hit_c [0:MAX_ENTRIES];
    logic [VALUE_BITS-1:0]  rv_c  [0:MAX_ENTRIES];
    logic [KEY_BITS-1:0]    lk_c  [0:MAX_ENTRIES];
    logic [VALUE_BITS-1:0]  lv_c  [0:MAX_ENTRIES];

    // handshakes
    assign cfg_ready   = 1'b1;
    assign out_free    = !m_valid_reg || m_tready;
    assign update_fire = (state_reg == ST_UPDATE) && out_free;
    assign s_tready    = (state_reg == ST_IDLE) || update_fire;
    assign accept      = s_tvalid && s_tready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_MATCH;
            end
            ST_MATCH: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) state_next = accept ? ST_MATCH : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg   <= s_tuser;
            key_reg   <= s_tdata[KEY_BITS-1:0];
            value_reg <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
        end
    end

    // last entry snapshot during compare
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MATCH) begin
            last_key_reg   <= lk_c[0];
            last_value_reg <= lv_c[0];
        end
    end

    // room check against saturated capacity
    assign cap_ext = LW'(cap_reg);
    assign limit   = (cap_ext > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : cap_ext;
    assign room    = LW'(count_reg) < limit;
    assign hit     = hit_c[0];

    // cell commands and result
    always_comb begin
        ctrl          = '0;
        ctrl.match_en = (state_reg == ST_MATCH);
        status_next   = ST_MISSING;
        rv_next       = '0;
        count_next    = count_reg;
        case (req_reg)
            REQ_INSERT: begin
                if (hit) begin
                    ctrl.replace = update_fire;
                    status_next  = ST_REPLACED;
                end else if (room) begin
                    ctrl.append  = update_fire;
                    status_next  = ST_INSERTED;
                    count_next   = count_reg + 1'b1;
                end else begin
                    status_next  = ST_FULL;
                end
            end
            REQ_LOOKUP: begin
                if (hit) begin
                    status_next = ST_FOUND;
                    rv_next     = rv_c[0];
                end
            end
            REQ_REMOVE: begin
                if (hit) begin
                    ctrl.move   = update_fire;
                    status_next = ST_REMOVED;
                    count_next  = count_reg - 1'b1;
                end
            end
            default: begin
                status_next = ST_MISSING;
            end
        endcase
    end

    // entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (update_fire) begin
            count_reg <= count_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (update_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (update_fire) begin
            status_reg  <= status_next;
            rv_reg      <= rv_next;
            cnt_out_reg <= COUNT_BITS'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = M_W'({cnt_out_reg, rv_reg});

    // row of slot cells
    assign hit_c[MAX_ENTRIES] = 1'b0;
    assign rv_c[MAX_ENTRIES]  = '0;
    assign lk_c[MAX_ENTRIES]  = '0;
    assign lv_c[MAX_ENTRIES]  = '0;

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        kvt_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .KEY_BITS    (KEY_BITS),
            .VALUE_BITS  (VALUE_BITS),
            .INDEX       (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .count      (count_reg),
            .req_key    (key_reg),
            .req_value  (value_reg),
            .last_key   (last_key_reg),
            .last_value (last_value_reg),
            .hit_in     (hit_c[i+1]),
            .rv_in      (rv_c[i+1]),
            .lk_in      (lk_c[i+1]),
            .lv_in      (lv_c[i+1]),
            .hit_out    (hit_c[i]),
            .rv_out     (rv_c[i]),
            .lk_out     (lk_c[i]),
            .lv_out     (lv_c[i])
        );
    end

endmodule
`default_nettype wire

### verif/key_value_table_unit_test.sv
// ----------------------------------------------------------------------------
// key_value_table_unit_test
// Self-checking bench for the key/value table. Insert, lookup and remove
// beats go in with random gaps and result back-pressure, a shadow table
// predicts every result beat, and the capacity register is stepped across
// its range between traffic phases.
// ----------------------------------------------------------------------------
module key_value_table_unit_test;
    import kvt_pkg::*;

    localparam int MAX_ENTRIES   = 16;
    localparam int KEY_BITS      = 32;
    localparam int VALUE_BITS    = 32;
    localparam int S_DATA_BITS   = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS   = ((VALUE_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 48;

    // request code the block must treat as a no-op miss
    localparam logic [REQ_BITS-1:0] REQ_RESERVED = 2'd3;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [VALUE_BITS-1:0]  read_value;
        logic [COUNT_BITS-1:0]  count;
    } table_result_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // tdata: key, value
    logic [S_DATA_BITS-1:0] s_tdata   = '0;
    // tuser: req_type
    logic [REQ_BITS-1:0]    s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // tdata: read_value, count
    logic [M_DATA_BITS-1:0] m_tdata;
    // tuser: status
    logic [STATUS_BITS-1:0] m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CAP_BITS-1:0]    cfg_data  = '0;

    // shadow copy of the table
    logic [KEY_BITS-1:0]    shadow_keys [MAX_ENTRIES];
    logic [VALUE_BITS-1:0]  shadow_vals [MAX_ENTRIES];
    int unsigned            shadow_count    = 0;
    logic [CAP_BITS-1:0]    shadow_capacity = CAP_RESET;

    table_result_t          pending_results [$];
    int                     error_count = 0;
    int                     idle_cycles = 0;
    bit                     tx_steady   = 1'b0;
    bit                     rx_steady   = 1'b0;
    int                     rx_hold     = 0;
    int                     rx_gap;

    key_value_table_unit #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 10);
        else             return $urandom_range(20, 60);
    endfunction

    // apply one request to the shadow table and return the result it gives
    function automatic table_result_t table_apply(input logic [REQ_BITS-1:0] req,
                                                  input logic [KEY_BITS-1:0] key,
                                                  input logic [VALUE_BITS-1:0] value);
        table_result_t res;
        int            slot;
        int unsigned   room;
        slot = -1;
        for (int i = 0; i < shadow_count; i++) begin
            if (slot < 0 && shadow_keys[i] == key) slot = i;
        end
        room = (shadow_capacity > MAX_ENTRIES) ? MAX_ENTRIES : shadow_capacity;
        res.status     = ST_MISSING;
        res.read_value = '0;
        case (req)
            REQ_INSERT: begin
                if (slot >= 0) begin
                    shadow_vals[slot] = value;
                    res.status = ST_REPLACED;
                end else if (shadow_count < room) begin
                    shadow_keys[shadow_count] = key;
                    shadow_vals[shadow_count] = value;
                    shadow_count++;
                    res.status = ST_INSERTED;
                end else begin
                    res.status = ST_FULL;
                end
            end
            REQ_LOOKUP: begin
                if (slot >= 0) begin
                    res.read_value = shadow_vals[slot];
                    res.status = ST_FOUND;
                end
            end
            REQ_REMOVE: begin
                // last entry fills the freed slot
                if (slot >= 0) begin
                    shadow_keys[slot] = shadow_keys[shadow_count - 1];
                    shadow_vals[slot] = shadow_vals[shadow_count - 1];
                    shadow_count--;
                    res.status = ST_REMOVED;
                end
            end
            default: ;
        endcase
        res.count = shadow_count[COUNT_BITS-1:0];
        return res;
    endfunction

    // one request beat, preceded by a random gap unless tx_steady is set
    task automatic send_request(input logic [REQ_BITS-1:0] req,
                                input logic [KEY_BITS-1:0] key,
                                input logic [VALUE_BITS-1:0] value);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= req;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(table_apply(req, key, value));
    endtask

    // stop sending and let every outstanding result drain
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_capacity = cap;
    endtask

    // misses on an empty table, reserved code included
    task automatic test_empty_table();
        send_request(REQ_LOOKUP, '0, '1);
        send_request(REQ_REMOVE, '1, '0);
        send_request(REQ_RESERVED, '0, '1);
    endtask

    // insert, replace, lookup and remove with the last entry moved down
    task automatic test_insert_replace_remove();
        send_request(REQ_INSERT, '0, '0);
        send_request(REQ_INSERT, '1, '1);
        send_request(REQ_LOOKUP, '0, '1);
        send_request(REQ_LOOKUP, '1, '0);
        send_request(REQ_INSERT, '0, 32'hA5A5_5A5A);
        send_request(REQ_LOOKUP, '0, '0);
        send_request(REQ_RESERVED, '1, '1);
        send_request(REQ_INSERT, 32'h8000_0001, 32'h7FFF_FFFE);
        send_request(REQ_REMOVE, '0, '0);
        send_request(REQ_LOOKUP, 32'h8000_0001, '0);
        send_request(REQ_LOOKUP, '0, '0);
        send_request(REQ_REMOVE, '0, '0);
        send_request(REQ_REMOVE, '1, '0);
        send_request(REQ_REMOVE, 32'h8000_0001, '0);
    endtask

    // zero capacity, a full table, and capacity lowered below the count
    task automatic test_capacity_edges();
        write_capacity(5'd0);
        send_request(REQ_INSERT, 32'h0000_1234, 32'h1111_1111);
        write_capacity(5'd2);
        send_request(REQ_INSERT, 32'h0000_1234, 32'h2222_2222);
        send_request(REQ_INSERT, 32'h0000_5678, 32'h3333_3333);
        send_request(REQ_INSERT, 32'h0000_9ABC, 32'h4444_4444);
        write_capacity(5'd1);
        send_request(REQ_INSERT, 32'h0000_9ABC, 32'h5555_5555);
        send_request(REQ_INSERT, 32'h0000_5678, 32'h6666_6666);
        send_request(REQ_REMOVE, 32'h0000_1234, '0);
        send_request(REQ_LOOKUP, 32'h0000_5678, '0);
    endtask

    // random traffic over a small key pool, one capacity per phase
    task automatic test_random_traffic();
        logic [CAP_BITS-1:0] caps [9];
        logic [KEY_BITS-1:0] pool [24];
        logic [REQ_BITS-1:0] req;
        logic [KEY_BITS-1:0] key;
        int                  pool_n;
        int                  ins_pct;
        int                  r;
        caps = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd8, 5'd1, 5'd20, 5'd5, 5'd12};
        for (int p = 0; p < 9; p++) begin
            write_capacity(p == 8 ? CAP_BITS'($urandom_range(0, 31)) : caps[p]);
            pool_n  = (p == 1) ? 24 : $urandom_range(4, 24);
            ins_pct = (p == 1) ? 70 : $urandom_range(30, 60);
            for (int i = 0; i < 24; i++) pool[i] = $urandom;
            pool[0] = '0;
            pool[1] = '1;
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 3)                 req = REQ_RESERVED;
                else if (r < 3 + ins_pct)  req = REQ_INSERT;
                else if (r[0])             req = REQ_LOOKUP;
                else                       req = REQ_REMOVE;
                key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
                send_request(req, key, $urandom);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (rx_steady) begin
            m_tready <= 1'b1;
        end else begin
            rx_gap = pick_gap();
            if (rx_gap == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                rx_hold  <= rx_gap - 1;
            end
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge aclk) begin : result_check
        table_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: status %0d, read_value %0h, count %0d",
                       m_tuser, m_tdata[VALUE_BITS-1:0],
                       m_tdata[VALUE_BITS +: COUNT_BITS]);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[VALUE_BITS-1:0] !== want.read_value) begin
                    $error("read_value mismatch: expected %0h, actual %0h",
                           want.read_value, m_tdata[VALUE_BITS-1:0]);
                    error_count++;
                end
                if (m_tdata[VALUE_BITS +: COUNT_BITS] !== want.count) begin
                    $error("count mismatch: expected %0d, actual %0d",
                           want.count, m_tdata[VALUE_BITS +: COUNT_BITS]);
                    error_count++;
                end
            end
        end
    end

    // give up when no beat moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_insert_replace_remove();
        test_capacity_edges();
        test_random_traffic();
        wait_for_results();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
